[hdl/sorted_tag_value_table_core_defines.svh]
// ----------------------------------------------------------------------------
// sorted tag/value table: assertion macros
// ----------------------------------------------------------------------------
`ifndef SORTED_TAG_VALUE_TABLE_CORE_DEFINES_SVH
`define SORTED_TAG_VALUE_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// plain property, checked out of reset
`define STVT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication, checked out of reset
`define STVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define STVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define STVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/stvt_pkg.sv]
// ----------------------------------------------------------------------------
// stvt_pkg
// Shared types and constants for the sorted tag/value table.
// ----------------------------------------------------------------------------
package stvt_pkg;

  localparam int CapacityDef = 16;
  localparam int TagW        = 32;
  localparam int ValW        = 32;
  localparam int PosW        = 4;
  localparam int CountW      = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [ValW-1:0] value;
  } entry_t;

endpackage

[hdl/stvt_store.sv]
// ----------------------------------------------------------------------------
// stvt_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stvt_store import stvt_pkg::*; #(
  parameter int Depth = CapacityDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wentry_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rentry_o
);

  entry_t mem_q [Depth];
  entry_t rentry_q;

  // contents are undefined until written, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wentry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rentry_q <= mem_q[raddr_i];
  end

  assign rentry_o = rentry_q;

endmodule

[hdl/sorted_tag_value_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_tag_value_table_core
// Sorted table of tag/value pairs with add, remove, get and read by position.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  input   | in  | in_valid_i / in_stall_o   | operation, tag_key, new_value, position
//  result  | out | out_valid_o / out_stall_i | status, value_out, tag_out, entry_count
//
//  one item at a time; the single memory read port and one comparator set the pace
//  search: per binary step, a midpoint read and a compare; then a hit check read
//  insert/remove: each moved entry is read, then written one slot over
//  read at index: registered read; a held result does not block the next input transfer
//  reset empties the table at once (count cleared), no clearing pass
// ----------------------------------------------------------------------------
`include "sorted_tag_value_table_core_defines.svh"

module sorted_tag_value_table_core import stvt_pkg::*; #(
  parameter int Capacity = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [TagW-1:0]   tag_key_i,
  input  logic [ValW-1:0]   new_value_i,
  input  logic [PosW-1:0]   position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [ValW-1:0]   value_out_o,
  output logic [TagW-1:0]   tag_out_o,
  output logic [CountW-1:0] entry_count_o
);

  localparam int AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW  = $clog2(Capacity + 1);
  localparam int XW    = CntW + PosW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_HITCHK,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_RDWAIT,
    S_FINISH
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [TagW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic [CntW-1:0]   fill_q;
  logic [CntW-1:0]   lo_q;
  logic [CntW-1:0]   hi_q;
  logic [CntW-1:0]   mid_q;
  logic [CntW-1:0]   idx_q;
  logic              hit_q;
  logic [ValW-1:0]   found_q;
  status_e           res_status_q;
  logic [ValW-1:0]   res_value_q;
  logic [TagW-1:0]   res_tag_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ValW-1:0]   out_value_q;
  logic [TagW-1:0]   out_tag_q;
  logic [CountW-1:0] out_count_q;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  entry_t            mem_wentry;
  logic [AddrW-1:0]  mem_raddr;
  entry_t            rentry;

  logic [CntW-1:0]   mid;
  logic [CntW:0]     idx_up;
  logic [CntW-1:0]   idx_dn;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     fill_x;
  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              full;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_up   = {1'b0, idx_q} + {{CntW{1'b0}}, 1'b1};
  assign idx_dn   = idx_q - {{(CntW-1){1'b0}}, 1'b1};
  assign pos_x    = XW'(position_i);
  assign fill_x   = XW'(fill_q);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_FINISH) && out_free;
  assign full     = (fill_q == CntW'(Capacity));

  // memory port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx_q[AddrW-1:0];
    mem_wentry = rentry;
    mem_raddr  = pos_x[AddrW-1:0];
    unique case (state_q)
      S_SEARCH: begin
        mem_raddr = (lo_q < hi_q) ? mid[AddrW-1:0] : lo_q[AddrW-1:0];
      end
      S_SHIFT_RD: begin
        mem_raddr = (op_q == OP_ADD) ? idx_dn[AddrW-1:0] : idx_up[AddrW-1:0];
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = lo_q[AddrW-1:0];
        mem_wentry = '{tag: key_q, value: val_q};
      end
      default: begin
      end
    endcase
  end

  stvt_store #(
    .Depth (Capacity),
    .AddrW (AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wentry_i (mem_wentry),
    .raddr_i  (mem_raddr),
    .rentry_o (rentry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ADD;
      key_q        <= '0;
      val_q        <= '0;
      fill_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      found_q      <= '0;
      res_status_q <= ST_OK;
      res_value_q  <= '0;
      res_tag_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_value_q  <= '0;
      out_tag_q    <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_q         <= op_e'(operation_i);
            key_q        <= tag_key_i;
            val_q        <= new_value_i;
            lo_q         <= '0;
            hi_q         <= fill_q;
            hit_q        <= 1'b0;
            res_value_q  <= '0;
            res_tag_q    <= '0;
            if (op_e'(operation_i) == OP_READ) begin
              if (pos_x < fill_x) begin
                res_status_q <= ST_OK;
                state_q      <= S_RDWAIT;
              end else begin
                res_status_q <= ST_RANGE;
                state_q      <= S_FINISH;
              end
            end else begin
              res_status_q <= ST_OK;
              state_q      <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          mid_q <= mid;
          if (lo_q < hi_q) begin
            state_q <= S_COMPARE;
          end else if (lo_q < fill_q) begin
            state_q <= S_HITCHK;
          end else begin
            state_q <= S_DISPATCH;
          end
        end
        S_COMPARE: begin
          if (rentry.tag < key_q) begin
            lo_q <= mid_q + {{(CntW-1){1'b0}}, 1'b1};
          end else begin
            hi_q <= mid_q;
          end
          state_q <= S_SEARCH;
        end
        S_HITCHK: begin
          hit_q   <= (rentry.tag == key_q);
          found_q <= rentry.value;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (op_q)
            OP_ADD: begin
              if (hit_q) begin
                state_q <= S_WRITE;
              end else if (full) begin
                res_status_q <= ST_FULL;
                state_q      <= S_FINISH;
              end else begin
                idx_q   <= fill_q;
                state_q <= S_SHIFT_RD;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                idx_q   <= lo_q;
                state_q <= S_SHIFT_RD;
              end else begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_FINISH;
              end
            end
            OP_GET: begin
              if (hit_q) begin
                res_value_q <= found_q;
              end else begin
                res_status_q <= ST_NOT_FOUND;
              end
              state_q <= S_FINISH;
            end
            OP_READ: begin
              state_q <= S_FINISH;
            end
          endcase
        end
        S_SHIFT_RD: begin
          if (op_q == OP_ADD) begin
            // move entries up by one from the top down to the slot
            state_q <= (idx_q > lo_q) ? S_SHIFT_WR : S_WRITE;
          end else if (idx_up < {1'b0, fill_q}) begin
            state_q <= S_SHIFT_WR;
          end else begin
            fill_q  <= fill_q - {{(CntW-1){1'b0}}, 1'b1};
            state_q <= S_FINISH;
          end
        end
        S_SHIFT_WR: begin
          idx_q   <= (op_q == OP_ADD) ? idx_dn : idx_up[CntW-1:0];
          state_q <= S_SHIFT_RD;
        end
        S_WRITE: begin
          if (!hit_q) begin
            fill_q <= fill_q + {{(CntW-1){1'b0}}, 1'b1};
          end
          state_q <= S_FINISH;
        end
        S_RDWAIT: begin
          res_value_q <= rentry.value;
          res_tag_q   <= rentry.tag;
          state_q     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_value_q  <= res_value_q;
            out_tag_q    <= res_tag_q;
            out_count_q  <= CountW'({{CountW{1'b0}}, fill_q});
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign value_out_o   = out_value_q;
  assign tag_out_o     = out_tag_q;
  assign entry_count_o = out_count_q;

  `STVT_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(Capacity), "fill above capacity")
  `STVT_ASSERT_IMP(a_we_busy, clk_i, rst_ni, mem_we, (state_q == S_SHIFT_WR) || (state_q == S_WRITE), "stray memory write")
  `STVT_ASSERT_IMP(a_search_order, clk_i, rst_ni, state_q == S_SEARCH, (lo_q <= hi_q) && (hi_q <= fill_q), "search bounds crossed")
  `STVT_ASSERT_IMP(a_fill_step, clk_i, rst_ni, fill_q != $past(fill_q), (fill_q == $past(fill_q) + 1'b1) || (fill_q + 1'b1 == $past(fill_q)), "fill jumped by more than one")

endmodule
